// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`endif
`endif

// ----- sv/qapm_pkg.sv -----
// ----------------------------------------------------------------------------
// qapm_pkg
// Types and constants of the attitude PID and motor mixer.
// ----------------------------------------------------------------------------
package qapm_pkg;

	localparam int HIGH_BAND    = 640;
	localparam int LOW_BAND     = 128;
	localparam int DECAY_FACTOR = 230;
	localparam int TILT_SHARE   = 192;
	localparam int MIN_MOTOR    = 10;
	localparam int MAX_MOTOR    = 240;
	localparam int HALF_TURN    = 11520;
	localparam int FULL_TURN    = 23040;
	localparam int TERM_SAT     = 131072;

	localparam int AW = 3;

	localparam logic [AW-1:0] REG_TGP = 3'd0;
	localparam logic [AW-1:0] REG_TGI = 3'd1;
	localparam logic [AW-1:0] REG_TGD = 3'd2;
	localparam logic [AW-1:0] REG_YGP = 3'd3;
	localparam logic [AW-1:0] REG_YGI = 3'd4;
	localparam logic [AW-1:0] REG_YGD = 3'd5;
	localparam logic [AW-1:0] REG_ILIM = 3'd6;
	localparam logic [AW-1:0] REG_ADD = 3'd7;

	typedef struct packed {
		logic signed [15:0] roll_meas;
		logic signed [15:0] pitch_meas;
		logic signed [15:0] yaw_meas;
		logic signed [15:0] roll_rate;
		logic signed [15:0] pitch_rate;
		logic signed [15:0] yaw_rate;
		logic signed [15:0] roll_target;
		logic signed [15:0] pitch_target;
		logic signed [15:0] yaw_target;
		logic        [7:0]  throttle;
	} in_item_t;

	typedef struct packed {
		logic [7:0] motor_one;
		logic [7:0] motor_two;
		logic [7:0] motor_three;
		logic [7:0] motor_four;
		logic       headroom_limited;
	} out_item_t;

	typedef struct packed {
		logic [15:0] tgp;
		logic [15:0] tgi;
		logic [15:0] tgd;
		logic [15:0] ygp;
		logic [15:0] ygi;
		logic [15:0] ygd;
		logic [22:0] ilim;
		logic [7:0]  add;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECAY,
		ST_INTEG,
		ST_MULP,
		ST_MULI,
		ST_MULD,
		ST_TERM,
		ST_SPLIT1,
		ST_SPLIT2,
		ST_MIX,
		ST_OUT
	} state_t;

	// 25x18 signed multiplier operands
	typedef struct packed {
		logic signed [24:0] a;
		logic signed [17:0] b;
	} mul_op_t;

endpackage

// ----- sv/quad_attitude_pid_mixer.sv -----
// ----------------------------------------------------------------------------
// quad_attitude_pid_mixer
// Three-axis banded leaky-integral PID with X-frame motor mixer.
//
//   channel  signals                        item
//   in       in_valid / in_stall / in_item  angles, rates, targets, throttle
//   out      out_valid / out_stall / out_item  four motors, limit flag
//   cfg      APB, paddr = 4*index           gains, limit, added throttle
//
// Each axis runs decay multiply, integral update, three gain multiplies and
// term through one shared 25x18 multiplier, then come two headroom splits
// and the mix. A new item is taken only once the last result is taken.
// in_stall is high from accept until the cycle after the result is taken.
// The result waits in an output register while out_stall is high. Reset
// clears state, axis count, integrals and out_valid, not the data registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module quad_attitude_pid_mixer
	import qapm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_item,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t cfg;
	state_t state_q, state_nx;
	in_item_t item_q;
	logic [1:0] ax_q;
	logic signed [23:0] integ_q [3];
	logic signed [16:0] err_q [3];
	logic signed [19:0] term_q [3];
	logic signed [44:0] acc_q;
	logic signed [19:0] tilt_q, yaw_q;
	logic lim_q;
	out_item_t out_q;
	logic out_valid_q;
	mul_op_t op;
	logic signed [42:0] prod;

	logic signed [16:0] e_roll, e_pitch, e_yaw0, e_yaw;
	logic signed [16:0] e_cur;
	logic [16:0] e_mag;
	logic signed [15:0] rate_cur;
	logic [15:0] gp, gi, gd;
	logic signed [24:0] iv, ilim_s;
	logic signed [44:0] t_sh;
	logic signed [19:0] t_sat;
	logic [8:0] at;
	logic signed [10:0] h_cnt;
	logic signed [19:0] h;
	logic signed [19:0] tmag, ymag, share, tnew, rest, ynew;
	logic signed [19:0] split_t, split_y;
	logic signed [19:0] base;

	qapm_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.cfg
	);

	qapm_mul u_mul (.clk, .op, .prod);

	assign e_roll  = 17'(item_q.roll_meas) + 17'(item_q.roll_target);
	assign e_pitch = 17'(item_q.pitch_meas) + 17'(item_q.pitch_target);
	assign e_yaw0  = 17'(item_q.yaw_meas) - 17'(item_q.yaw_target);
	always_comb begin
		e_yaw = e_yaw0;
		if (e_yaw0 > 17'(HALF_TURN)) e_yaw = e_yaw0 - 17'(FULL_TURN);
		else if (e_yaw0 < -17'(HALF_TURN)) e_yaw = e_yaw0 + 17'(FULL_TURN);
	end

	always_comb begin
		case (ax_q)
			2'd0:    begin e_cur = err_q[0]; rate_cur = item_q.roll_rate; end
			2'd1:    begin e_cur = err_q[1]; rate_cur = item_q.pitch_rate; end
			default: begin e_cur = err_q[2]; rate_cur = item_q.yaw_rate; end
		endcase
		gp = (ax_q == 2'd2) ? cfg.ygp : cfg.tgp;
		gi = (ax_q == 2'd2) ? cfg.ygi : cfg.tgi;
		gd = (ax_q == 2'd2) ? cfg.ygd : cfg.tgd;
		e_mag = e_cur[16] ? 17'(-e_cur) : 17'(e_cur);
	end

	always_comb begin
		op.a = '0;
		op.b = '0;
		unique case (state_q)
			ST_DECAY: begin op.a = 25'(integ_q[ax_q]); op.b = 18'(DECAY_FACTOR); end
			ST_MULP:  begin op.a = 25'(e_cur); op.b = $signed({2'b0, gp}); end
			ST_MULI:  begin op.a = 25'(integ_q[ax_q]); op.b = $signed({2'b0, gi}); end
			ST_MULD:  begin op.a = 25'(rate_cur) <<< 2; op.b = $signed({2'b0, gd}); end
			default: ;
		endcase
	end

	// integral: decayed sum in band, plain sum below, held above, then clamped
	always_comb begin
		ilim_s = $signed({2'b0, cfg.ilim});
		iv = 25'(integ_q[ax_q]);
		if (e_mag < 17'(HIGH_BAND)) begin
			if (e_mag >= 17'(LOW_BAND)) iv = 25'(prod >>> 8) + 25'(e_cur);
			else iv = iv + 25'(e_cur);
		end
		if (iv > ilim_s) iv = ilim_s;
		if (iv < -ilim_s) iv = -ilim_s;
	end

	// rate product lands in ST_TERM
	always_comb begin
		t_sh = (acc_q + 45'(prod)) >>> 6;
		if (t_sh > 45'(TERM_SAT)) t_sat = 20'(TERM_SAT);
		else if (t_sh < -45'(TERM_SAT)) t_sat = -20'(TERM_SAT);
		else t_sat = 20'(t_sh);
	end

	always_comb begin
		at = 9'(cfg.add) + 9'(item_q.throttle);
		h_cnt = 11'(MAX_MOTOR - MIN_MOTOR) - 11'(at);
		if ($signed(11'(at)) < h_cnt) h_cnt = 11'(at);
		if (h_cnt < 0) h_cnt = '0;
		h = 20'(h_cnt) <<< 8;
		base = (20'(at) + 20'(MIN_MOTOR)) <<< 8;
	end

	always_comb begin
		tmag = tilt_q < 0 ? -tilt_q : tilt_q;
		ymag = yaw_q < 0 ? -yaw_q : yaw_q;
		share = 20'((28'(h) * 28'(TILT_SHARE)) >>> 8);
		tnew = share < tmag ? share : tmag;
		rest = h - tnew;
		ynew = rest < ymag ? rest : ymag;
		split_t = tilt_q < 0 ? -tnew : (tilt_q > 0 ? tnew : 20'sd0);
		split_y = yaw_q < 0 ? -ynew : (yaw_q > 0 ? ynew : 20'sd0);
	end

	function automatic logic [7:0] clampm(input logic signed [21:0] v);
		logic signed [21:0] w;
		w = v;
		if (w < 22'(MIN_MOTOR * 256)) w = 22'(MIN_MOTOR * 256);
		if (w > 22'(MAX_MOTOR * 256)) w = 22'(MAX_MOTOR * 256);
		return w[15:8];
	endfunction

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_nx = ST_DECAY;
			ST_DECAY:  state_nx = ST_INTEG;
			ST_INTEG:  state_nx = ST_MULP;
			ST_MULP:   state_nx = ST_MULI;
			ST_MULI:   state_nx = ST_MULD;
			ST_MULD:   state_nx = ST_TERM;
			ST_TERM:   state_nx = (ax_q == 2'd2) ? ST_SPLIT1 : ST_DECAY;
			ST_SPLIT1: state_nx = ST_SPLIT2;
			ST_SPLIT2: state_nx = ST_MIX;
			ST_MIX:    state_nx = ST_OUT;
			ST_OUT:    if (!out_stall) state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ax_q <= '0;
			integ_q[0] <= '0;
			integ_q[1] <= '0;
			integ_q[2] <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			out_valid_q <= (state_nx == ST_OUT);
			if (state_q == ST_IDLE) ax_q <= '0;
			if (state_q == ST_INTEG) integ_q[ax_q] <= 24'(iv);
			if (state_q == ST_TERM) ax_q <= ax_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				item_q <= in_item;
				lim_q <= 1'b0;
			end
			ST_DECAY: if (ax_q == 2'd0) begin
				err_q[0] <= e_roll;
				err_q[1] <= e_pitch;
				err_q[2] <= e_yaw;
			end
			ST_MULI:  acc_q <= 45'(prod);
			ST_MULD:  acc_q <= acc_q + 45'(prod);
			ST_TERM:  term_q[ax_q] <= t_sat;
			default: ;
		endcase
		if (state_q == ST_TERM && ax_q == 2'd2) begin
			tilt_q <= term_q[0];
			yaw_q <= t_sat;
		end
		if (state_q == ST_SPLIT1) begin
			if (tmag + ymag >= h) begin
				term_q[0] <= split_t;
				yaw_q <= split_y;
				lim_q <= 1'b1;
			end
			tilt_q <= term_q[1];
		end
		if (state_q == ST_SPLIT2) begin
			if (tmag + ymag >= h) begin
				term_q[1] <= split_t;
				term_q[2] <= split_y;
				lim_q <= 1'b1;
			end else begin
				term_q[2] <= yaw_q;
			end
		end
		if (state_q == ST_MIX) begin
			out_q.motor_one <= clampm(22'(base) - 22'(term_q[0]) + 22'(term_q[2]));
			out_q.motor_two <= clampm(22'(base) + 22'(term_q[1]) - 22'(term_q[2]));
			out_q.motor_three <= clampm(22'(base) + 22'(term_q[0]) + 22'(term_q[2]));
			out_q.motor_four <= clampm(22'(base) - 22'(term_q[1]) - 22'(term_q[2]));
			out_q.headroom_limited <= lim_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;

	`ASSERT_IMPL(a_busy_stall, clk, arst_n, (state_q != ST_IDLE) |-> in_stall)
	`ASSERT_IMPL(a_out_state, clk, arst_n, out_valid |-> (state_q == ST_OUT))
	`ASSERT_IMPL(a_accept_start, clk, arst_n, (in_valid && !in_stall) |=> (state_q == ST_DECAY))

endmodule

// ----- sv/qapm_regs.sv -----
// ----------------------------------------------------------------------------
// qapm_regs
// APB register file for gains, integral limit and added throttle.
// ----------------------------------------------------------------------------
module qapm_regs
	import qapm_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [4:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	output cfg_t          cfg
);

	cfg_t cfg_q;
	logic [AW-1:0] idx;

	assign idx = paddr[4:2];
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{tgp: '0, tgi: '0, tgd: '0, ygp: '0, ygi: '0, ygd: '0,
				ilim: 23'd65536, add: '0};
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_TGP:  cfg_q.tgp <= pwdata[15:0];
				REG_TGI:  cfg_q.tgi <= pwdata[15:0];
				REG_TGD:  cfg_q.tgd <= pwdata[15:0];
				REG_YGP:  cfg_q.ygp <= pwdata[15:0];
				REG_YGI:  cfg_q.ygi <= pwdata[15:0];
				REG_YGD:  cfg_q.ygd <= pwdata[15:0];
				REG_ILIM: cfg_q.ilim <= pwdata[22:0];
				REG_ADD:  cfg_q.add <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_TGP:  prdata = {16'd0, cfg_q.tgp};
			REG_TGI:  prdata = {16'd0, cfg_q.tgi};
			REG_TGD:  prdata = {16'd0, cfg_q.tgd};
			REG_YGP:  prdata = {16'd0, cfg_q.ygp};
			REG_YGI:  prdata = {16'd0, cfg_q.ygi};
			REG_YGD:  prdata = {16'd0, cfg_q.ygd};
			REG_ILIM: prdata = {9'd0, cfg_q.ilim};
			REG_ADD:  prdata = {24'd0, cfg_q.add};
			default:  prdata = '0;
		endcase
	end

endmodule

// ----- sv/qapm_mul.sv -----
// ----------------------------------------------------------------------------
// qapm_mul
// Shared signed multiplier, registered product.
// ----------------------------------------------------------------------------
module qapm_mul
	import qapm_pkg::*;
(
	input  logic               clk,
	input  mul_op_t            op,
	output logic signed [42:0] prod
);

	logic signed [42:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= 43'(op.a) * 43'(op.b);
	end

	assign prod = prod_q;

endmodule

// ----- tb/sv/tb_quad_attitude_pid_mixer.sv -----
// ----------------------------------------------------------------------------
// tb_quad_attitude_pid_mixer
// Self-checking bench: a mixer model predicts the four motor commands and the
// limit flag of every item; random items, gains and handshake gaps.
// ----------------------------------------------------------------------------
module tb_quad_attitude_pid_mixer;
	import qapm_pkg::*;

	class motor_board;
		cfg_t cfg;
		longint integ[3];
		out_item_t pending[$];
		int errors;
		int checked;

		function new();
			cfg = '0;
			cfg.ilim = 23'd65536;
			integ = '{0, 0, 0};
			errors = 0;
			checked = 0;
		endfunction

		function longint fshr(longint v, int s);
			return v >>> s;
		endfunction

		function longint absv(longint v);
			return v < 0 ? -v : v;
		endfunction

		function longint signed_as(longint r, longint m);
			return r < 0 ? -m : (r > 0 ? m : 0);
		endfunction

		function void update_integ(int ax, longint e);
			longint v;
			longint lim;
			v = integ[ax];
			lim = longint'(cfg.ilim);
			if (absv(e) < HIGH_BAND) begin
				if (absv(e) >= LOW_BAND)
					v = fshr(v * DECAY_FACTOR, 8);
				v += e;
			end
			if (v > lim) v = lim;
			if (v < -lim) v = -lim;
			integ[ax] = v;
		endfunction

		function longint correction(longint gp, longint gi, longint gd, longint e,
			longint i, longint r);
			longint q;
			q = fshr(gp * e + gi * i + 4 * gd * r, 6);
			if (q > TERM_SAT) q = TERM_SAT;
			if (q < -TERM_SAT) q = -TERM_SAT;
			return q;
		endfunction

		function bit share(ref longint tilt, ref longint yw, input longint h);
			longint m;
			if (absv(tilt) + absv(yw) < h)
				return 0;
			m = fshr(TILT_SHARE * h, 8);
			if (absv(tilt) < m) m = absv(tilt);
			tilt = signed_as(tilt, m);
			m = h - absv(tilt);
			if (absv(yw) < m) m = absv(yw);
			yw = signed_as(yw, m);
			return 1;
		endfunction

		function logic [7:0] clamp_motor(longint v);
			if (v < MIN_MOTOR * 256) v = MIN_MOTOR * 256;
			if (v > MAX_MOTOR * 256) v = MAX_MOTOR * 256;
			return v[15:8];
		endfunction

		function void note_input(in_item_t it);
			longint er, ep, ey, r, p, y, h, a, t, base;
			bit l1, l2;
			out_item_t o;
			er = longint'(it.roll_meas) + longint'(it.roll_target);
			ep = longint'(it.pitch_meas) + longint'(it.pitch_target);
			ey = longint'(it.yaw_meas) - longint'(it.yaw_target);
			if (ey > HALF_TURN) ey -= FULL_TURN;
			if (ey < -HALF_TURN) ey += FULL_TURN;
			update_integ(0, er);
			update_integ(1, ep);
			update_integ(2, ey);
			r = correction(cfg.tgp, cfg.tgi, cfg.tgd, er, integ[0], longint'(it.roll_rate));
			p = correction(cfg.tgp, cfg.tgi, cfg.tgd, ep, integ[1], longint'(it.pitch_rate));
			y = correction(cfg.ygp, cfg.ygi, cfg.ygd, ey, integ[2], longint'(it.yaw_rate));
			a = cfg.add;
			t = it.throttle;
			h = a + t;
			if (MAX_MOTOR - a - t - MIN_MOTOR < h) h = MAX_MOTOR - a - t - MIN_MOTOR;
			if (h < 0) h = 0;
			h *= 256;
			l1 = share(r, y, h);
			l2 = share(p, y, h);
			base = (MIN_MOTOR + a + t) * 256;
			o.motor_one = clamp_motor(base - r + y);
			o.motor_two = clamp_motor(base + p - y);
			o.motor_three = clamp_motor(base + r + y);
			o.motor_four = clamp_motor(base - p - y);
			o.headroom_limited = l1 | l2;
			pending.push_back(o);
		endfunction

		function void check_output(out_item_t got);
			out_item_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected motor item %h", got);
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("motor mismatch: expected %h actual %h", want, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_item;
	logic out_valid;
	logic out_stall;
	out_item_t out_item;
	logic psel, penable, pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	motor_board board;
	int sent;
	int quiet;
	bit calm;
	bit hold_rx;

	quad_attitude_pid_mixer DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_output(out_item);
		if (hold_rx)
			out_stall <= 1;
		else if (calm)
			out_stall <= 0;
		else
			out_stall <= ($urandom_range(99) < 29);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > 20000) begin
			$display("tb_quad_attitude_pid_mixer failed");
			$finish;
		end
	end

	task automatic write_reg(input logic [AW-1:0] idx, input logic [31:0] val);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (idx)
			REG_TGP: board.cfg.tgp = val[15:0];
			REG_TGI: board.cfg.tgi = val[15:0];
			REG_TGD: board.cfg.tgd = val[15:0];
			REG_YGP: board.cfg.ygp = val[15:0];
			REG_YGI: board.cfg.ygi = val[15:0];
			REG_YGD: board.cfg.ygd = val[15:0];
			REG_ILIM: board.cfg.ilim = val[22:0];
			default: board.cfg.add = val[7:0];
		endcase
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic send_item(input in_item_t it, input bit gaps);
		if (gaps) begin
			while ($urandom_range(99) < 29) begin
				in_valid <= 0;
				@(posedge clk);
			end
		end
		in_valid <= 1;
		in_item <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_input(it);
		sent++;
	endtask

	function automatic in_item_t rand_item(bit tame);
		in_item_t it;
		logic [159:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
		it = raw[$bits(in_item_t)-1:0];
		if (tame) begin
			it.roll_meas = 16'(int'($urandom_range(1400)) - 700);
			it.pitch_meas = 16'(int'($urandom_range(1400)) - 700);
			it.yaw_meas = 16'(int'($urandom_range(1400)) - 700);
			it.roll_target = 16'(int'($urandom_range(200)) - 100);
			it.pitch_target = 16'(int'($urandom_range(200)) - 100);
			it.yaw_target = 16'(int'($urandom_range(200)) - 100);
			it.roll_rate = 16'(int'($urandom_range(2000)) - 1000);
			it.pitch_rate = 16'(int'($urandom_range(2000)) - 1000);
			it.yaw_rate = 16'(int'($urandom_range(2000)) - 1000);
			it.throttle = 8'($urandom_range(160));
		end
		return it;
	endfunction

	task automatic random_gains(bit extreme);
		logic [AW-1:0] k;
		for (int i = 0; i < 6; i++) begin
			k = AW'(i);
			write_reg(k, extreme ? 32'hFFFF : $urandom_range(extreme ? 0 : 1500));
		end
		write_reg(REG_ILIM, extreme ? 32'h7FFFFF : $urandom_range(200000));
		write_reg(REG_ADD, extreme ? 32'hFF : $urandom_range(60));
	endtask

	initial begin
		in_item_t it;
		in_valid = 0;
		in_item = '0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		board = new();
		sent = 0;
		calm = 0;
		hold_rx = 0;
		@(posedge arst_n);
		@(posedge clk);

		// directed: reset gains, then extremes and special cases
		it = '0;
		send_item(it, 0);
		it.roll_meas = 16'sh7FFF; it.roll_target = 16'sh7FFF;
		it.pitch_meas = -16'sh8000; it.pitch_target = -16'sh8000;
		it.yaw_meas = 16'sh7FFF; it.yaw_target = -16'sh8000;
		it.roll_rate = 16'sh7FFF; it.pitch_rate = -16'sh8000; it.yaw_rate = 16'sh7FFF;
		it.throttle = 8'hFF;
		send_item(it, 0);
		drain();
		write_reg(REG_TGP, 32'd300);
		write_reg(REG_TGI, 32'd40);
		write_reg(REG_TGD, 32'd20);
		write_reg(REG_YGP, 32'd200);
		write_reg(REG_YGI, 32'd30);
		write_reg(REG_YGD, 32'd10);
		write_reg(REG_ILIM, 32'd5000);
		write_reg(REG_ADD, 32'd20);
		for (int b = 0; b < 16; b++) begin
			it = '0;
			it.throttle = 8'd100;
			it.roll_meas = 16'(b < 8 ? 1 << b : 0);
			it.pitch_meas = 16'(100 + b * 40);
			it.yaw_meas = 16'(b * 1500);
			it.yaw_target = -16'(b * 1500);
			send_item(it, 0);
		end
		it = rand_item(1);
		it.throttle = 8'd0;
		send_item(it, 0);
		it.throttle = 8'd210;
		send_item(it, 0);
		drain();
		write_reg(REG_ILIM, 32'd10);
		send_item(rand_item(1), 0);
		drain();
		random_gains(1);
		repeat (4) send_item(rand_item(0), 0);
		drain();
		write_reg(REG_ILIM, 32'd0);
		write_reg(REG_ADD, 32'd0);
		for (int i = 0; i < 6; i++) write_reg(AW'(i), 32'd0);
		send_item(rand_item(0), 0);
		drain();

		// random phases
		for (int ph = 0; ph < 6; ph++) begin
			random_gains(ph == 5);
			calm = (ph == 2);
			for (int n = 0; n < 90; n++) begin
				if (ph == 3 && n == 10) begin
					hold_rx = 1;
					fork
						begin
							repeat (200) @(posedge clk);
							hold_rx = 0;
						end
					join_none
				end
				if (n == 45) drain();
				send_item(rand_item($urandom_range(99) < 80), !calm);
			end
			calm = 0;
			drain();
		end

		$display("%0d items sent, %0d results checked across zero, extreme and random gains",
			sent, board.checked);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("tb_quad_attitude_pid_mixer passed");
		else
			$display("tb_quad_attitude_pid_mixer failed");
		$finish;
	end
endmodule
